// File: rtl/diode_ladder_lowpass_assert.svh
// Assertion macros shared by the filter RTL.
// Expects clk and rst in the scope of use; no other dependencies.
`ifndef DIODE_LADDER_LOWPASS_ASSERT_SVH
`define DIODE_LADDER_LOWPASS_ASSERT_SVH

// check in the same cycle
`define DLL_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// check in the next cycle
`define DLL_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/dll_pkg.sv
// Package for the diode-ladder lowpass: constants, register codes, rounding helpers
// and the elaboration-time tanh table builder. No dependencies.
`default_nettype none

package dll_pkg;

  localparam int STAGE_COUNT      = 4;
  localparam int NEWTON_STEPS_DEF = 4;
  localparam int TANH_DEPTH_DEF   = 256;
  localparam int CF_TERMS         = 24;
  localparam int SAMPLE_W         = 24;
  localparam int GAIN_W           = 24;
  localparam int RES_W            = 17;
  localparam int CFG_IDX_W        = 3;
  localparam int WIDE_W           = 66;
  localparam int DIV_BITS         = 60;

  typedef logic signed [WIDE_W-1:0] wide_t;

  localparam wide_t ONE24  = 66'sd16777216;
  localparam wide_t S32MAX = 66'sd2147483647;
  localparam wide_t S32MIN = -66'sd2147483648;

  localparam logic [RES_W-1:0] RES_MAX = 17'd65536;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd8388608;

  // register indexes on the write port
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RESONANCE = 3'd4;

  // action codes carried in tuser
  localparam logic ACT_FILTER = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  // add half an LSB, then shift right with floor
  function automatic wide_t rnd(input wide_t v, input int sh);
    rnd = (v + (wide_t'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic logic signed [31:0] sat32(input wide_t v);
    if (v > S32MAX) begin
      sat32 = 32'(S32MAX);
    end else if (v < S32MIN) begin
      sat32 = 32'(S32MIN);
    end else begin
      sat32 = 32'(v);
    end
  endfunction

  // shift-subtract divide, used only while building constants
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r = r - d;
        q[b] = 1'b1;
      end
    end
    udiv64 = q;
  endfunction

  // tanh at 4*i/depth in Q0.24 from a continued fraction
  function automatic logic [23:0] tanh_entry(input int i, input int depth);
    logic [63:0] xi;
    logic [63:0] x2;
    logic [63:0] d;
    logic [63:0] t;
    xi = udiv64(64'(i) << 26, 64'(depth));
    x2 = (xi * xi + (64'd1 << 23)) >> 24;
    d  = 64'(2 * CF_TERMS + 1) << 24;
    for (int n = CF_TERMS - 1; n >= 0; n--) begin
      d = (64'(2 * n + 1) << 24) + udiv64(x2 << 24, d);
    end
    t = udiv64(xi << 24, d);
    if (t > 64'd16777215) begin
      t = 64'd16777215;
    end
    tanh_entry = t[23:0];
  endfunction

  // interpolated tanh of the diode bias (0.25 in Q.20)
  function automatic logic [23:0] bias_tanh(input int depth);
    logic [63:0] p;
    logic [63:0] idx;
    logic [63:0] fr;
    logic [63:0] lo;
    logic [63:0] hi;
    p   = 64'd262144 * 64'(depth);
    idx = p >> 22;
    fr  = p & 64'h3FFFFF;
    lo  = 64'(tanh_entry(int'(idx), depth));
    hi  = 64'(tanh_entry(int'(idx) + 1, depth));
    bias_tanh = 24'(lo + (((hi - lo) * fr) >> 22));
  endfunction

endpackage

`default_nettype wire

// File: rtl/diode_ladder_lowpass.sv
// A filter item runs through the shared multiplier sequence, the 60-bit bit-serial divider
// and the Newton steps before its result; a clear item goes straight to the output register.
// The block takes no new item until the last one has been loaded into the output register.
// The next item is accepted while a result still waits in the output register.
// Reset (synchronous, rst high) zeroes the stage states and loads the register defaults.
// Depends on dll_pkg and diode_ladder_lowpass_assert.svh.
`default_nettype none

`include "diode_ladder_lowpass_assert.svh"

module diode_ladder_lowpass #(
  parameter int NEWTON_STEPS     = dll_pkg::NEWTON_STEPS_DEF,
  parameter int TANH_TABLE_DEPTH = dll_pkg::TANH_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [23:0] sample_in
  input  logic [0:0]  s_axis_tuser,   // [0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [23:0] sample_out
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [23:0] wr_data
);

  localparam int TAB_IW = $clog2(TANH_TABLE_DEPTH + 1);
  localparam int NS_W   = $clog2(NEWTON_STEPS + 1);
  localparam int P_W    = 33 + TAB_IW;
  localparam logic [23:0] TANH_BIAS = dll_pkg::bias_tanh(TANH_TABLE_DEPTH);

  typedef enum logic [20:0] {
    ST_IDLE  = 21'h000001,
    ST_SCALE = 21'h000002,
    ST_A0    = 21'h000004,
    ST_A1    = 21'h000008,
    ST_A2    = 21'h000010,
    ST_B0    = 21'h000020,
    ST_B1    = 21'h000040,
    ST_B2    = 21'h000080,
    ST_CK    = 21'h000100,
    ST_XIN   = 21'h000200,
    ST_AK    = 21'h000400,
    ST_NUM   = 21'h000800,
    ST_DIV   = 21'h001000,
    ST_TLOOK = 21'h002000,
    ST_TINT  = 21'h004000,
    ST_KD    = 21'h008000,
    ST_F     = 21'h010000,
    ST_TT    = 21'h020000,
    ST_DD    = 21'h040000,
    ST_STG   = 21'h080000,
    ST_OUT   = 21'h100000
  } state_t;

  state_t state;
  logic   phase;
  logic [1:0] cnt;
  logic [NS_W-1:0] nstep;
  logic   div_first;

  // configuration
  logic [23:0] gain [dll_pkg::STAGE_COUNT];
  logic [16:0] res;
  logic [16:0] r_eff;
  logic [19:0] k17;

  // working registers
  logic signed [31:0] st [dll_pkg::STAGE_COUNT];
  logic signed [31:0] sc [dll_pkg::STAGE_COUNT];
  logic signed [23:0] x_smp;
  logic signed [25:0] a_gain;
  logic signed [34:0] b_acc;
  logic [25:0]        ck24;
  logic signed [31:0] xin;
  logic signed [28:0] ak24;
  logic signed [31:0] y4;
  logic signed [24:0] tval;
  logic signed [33:0] inner;
  logic signed [35:0] f_val;
  logic signed [25:0] slope;
  logic signed [31:0] y_stage;

  // tanh lookup
  logic [23:0] tanh_rom [TANH_TABLE_DEPTH + 1];
  logic [23:0] tab_lo;
  logic [23:0] tab_hi;
  logic [21:0] frac;
  logic        t_neg;
  logic signed [32:0] z;
  logic [32:0] z_mag;
  logic [P_W-1:0] p_pos;
  logic [P_W-1:0] idx_full;
  logic        idx_big;
  logic [TAB_IW-1:0] lo_idx;
  logic [TAB_IW-1:0] hi_idx;

  // shared multiplier
  logic signed [35:0] mul_a;
  logic signed [28:0] mul_b;
  logic signed [64:0] prod;
  dll_pkg::wide_t w;
  dll_pkg::wide_t r24;
  dll_pkg::wide_t r21;
  dll_pkg::wide_t r17;
  dll_pkg::wide_t tm;
  dll_pkg::wide_t inner_w;
  logic signed [31:0] stg_y;

  // bit-serial divider
  logic [59:0] div_q;
  logic [27:0] div_dsr;
  logic [27:0] div_rem;
  logic        div_neg;
  logic [5:0]  div_cnt;
  logic [28:0] trial;
  logic        trial_ge;
  dll_pkg::wide_t q_w;
  dll_pkg::wide_t dl_val;
  dll_pkg::wide_t dl_mag;
  dll_pkg::wide_t dl_dsr;

  for (genvar gi = 0; gi <= TANH_TABLE_DEPTH; gi++) begin : g_rom
    assign tanh_rom[gi] = dll_pkg::tanh_entry(gi, TANH_TABLE_DEPTH);
  end

  assign s_axis_tready = (state == ST_IDLE);

  assign r_eff = (res > dll_pkg::RES_MAX) ? dll_pkg::RES_MAX : res;
  assign k17   = (20'(r_eff) << 3) + (20'(r_eff) << 2) + 20'(r_eff);

  assign w   = dll_pkg::wide_t'(prod);
  assign r24 = dll_pkg::rnd(w, 24);
  assign r21 = dll_pkg::rnd(w, 21);
  assign r17 = dll_pkg::rnd(w, 17);
  assign tm  = dll_pkg::wide_t'($signed({1'b0, tab_lo})) + (w >>> 22);
  assign inner_w = dll_pkg::wide_t'(xin) - r21;
  assign stg_y   = dll_pkg::sat32(r24 + dll_pkg::wide_t'(st[cnt]));

  // table address for |y4 + bias|
  assign z        = 33'(y4) + 33'sd262144;
  assign z_mag    = z[32] ? 33'(-z) : 33'(z);
  assign p_pos    = P_W'(z_mag) * P_W'(TANH_TABLE_DEPTH);
  assign idx_full = p_pos >> 22;
  assign idx_big  = (idx_full >= P_W'(TANH_TABLE_DEPTH));
  assign lo_idx   = idx_big ? TAB_IW'(TANH_TABLE_DEPTH) : idx_full[TAB_IW-1:0];
  assign hi_idx   = idx_big ? TAB_IW'(TANH_TABLE_DEPTH) : TAB_IW'(idx_full[TAB_IW-1:0] + 1'b1);

  assign trial    = {div_rem, div_q[59]};
  assign trial_ge = (trial >= {1'b0, div_dsr});
  assign q_w      = div_neg ? -dll_pkg::wide_t'({6'd0, div_q})
                            : dll_pkg::wide_t'({6'd0, div_q});
  assign dl_val   = (state == ST_NUM) ? r24 + dll_pkg::wide_t'(b_acc)
                                      : dll_pkg::wide_t'(f_val);
  assign dl_mag   = dl_val[65] ? -dl_val : dl_val;
  assign dl_dsr   = (state == ST_NUM) ? dll_pkg::ONE24 + dll_pkg::wide_t'(ak24)
                                      : dll_pkg::ONE24 + r24;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_SCALE: begin
        mul_a = 36'(st[cnt]);
        mul_b = $signed({4'b0, 25'(25'h1000000 - {1'b0, gain[cnt]})});
      end
      ST_A0: begin
        mul_a = $signed({12'b0, gain[0]});
        mul_b = $signed({5'b0, gain[1]});
      end
      ST_A1: begin
        mul_a = 36'(a_gain);
        mul_b = $signed({5'b0, gain[2]});
      end
      ST_A2: begin
        mul_a = 36'(a_gain);
        mul_b = $signed({5'b0, gain[3]});
      end
      ST_B0: begin
        mul_a = 36'(sc[0]);
        mul_b = $signed({5'b0, gain[1]});
      end
      ST_B1: begin
        mul_a = 36'(b_acc);
        mul_b = $signed({5'b0, gain[2]});
      end
      ST_B2: begin
        mul_a = 36'(b_acc);
        mul_b = $signed({5'b0, gain[3]});
      end
      ST_CK: begin
        mul_a = $signed({19'b0, r_eff});
        mul_b = $signed({9'b0, k17});
      end
      ST_XIN: begin
        mul_a = 36'(x_smp);
        mul_b = $signed({2'b0, 27'(27'h1000000 + {1'b0, ck24})});
      end
      ST_AK: begin
        mul_a = $signed({16'b0, k17});
        mul_b = 29'(a_gain);
      end
      ST_NUM: begin
        mul_a = 36'(xin);
        mul_b = 29'(a_gain);
      end
      ST_TINT: begin
        mul_a = 36'($signed({1'b0, tab_hi}) - $signed({1'b0, tab_lo}));
        mul_b = $signed({7'b0, frac});
      end
      ST_KD: begin
        mul_a = 36'(tval) - 36'($signed({1'b0, TANH_BIAS}));
        mul_b = $signed({9'b0, k17});
      end
      ST_F: begin
        mul_a = 36'(inner);
        mul_b = 29'(a_gain);
      end
      ST_TT: begin
        mul_a = 36'(tval);
        mul_b = 29'(tval);
      end
      ST_DD: begin
        mul_a = 36'(ak24);
        mul_b = 29'(slope);
      end
      ST_STG: begin
        mul_a = 36'(y_stage) - 36'(st[cnt]);
        mul_b = $signed({5'b0, gain[cnt]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < dll_pkg::STAGE_COUNT; i++) begin
        gain[i] <= dll_pkg::GAIN_RESET;
      end
      res <= '0;
    end else if (wr_en) begin
      case (wr_index)
        dll_pkg::REG_GAIN_0:    gain[0] <= wr_data;
        dll_pkg::REG_GAIN_1:    gain[1] <= wr_data;
        dll_pkg::REG_GAIN_2:    gain[2] <= wr_data;
        dll_pkg::REG_GAIN_3:    gain[3] <= wr_data;
        dll_pkg::REG_RESONANCE: res     <= wr_data[16:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= 65'(mul_a) * 65'(mul_b);
    if (rst) begin
      state         <= ST_IDLE;
      phase         <= 1'b0;
      cnt           <= '0;
      nstep         <= '0;
      div_first     <= 1'b1;
      div_cnt       <= '0;
      div_dsr       <= 28'h1000000;
      m_axis_tvalid <= 1'b0;
      for (int i = 0; i < dll_pkg::STAGE_COUNT; i++) begin
        st[i] <= '0;
      end
    end else begin
      // ST_OUT reloads the output register itself
      if (m_axis_tvalid && m_axis_tready && (state != ST_OUT)) begin
        m_axis_tvalid <= 1'b0;
      end
      // multiplier steps: issue on phase low, write back on phase high
      if (state inside {ST_SCALE, ST_A0, ST_A1, ST_A2, ST_B0, ST_B1, ST_B2, ST_CK,
                        ST_XIN, ST_AK, ST_NUM, ST_TINT, ST_KD, ST_F, ST_TT, ST_DD,
                        ST_STG}) begin
        phase <= ~phase;
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            if (s_axis_tuser[0] == dll_pkg::ACT_CLEAR) begin
              for (int i = 0; i < dll_pkg::STAGE_COUNT; i++) begin
                st[i] <= '0;
              end
              y_stage <= '0;
              state   <= ST_OUT;
            end else begin
              x_smp <= s_axis_tdata;
              cnt   <= '0;
              phase <= 1'b0;
              nstep <= '0;
              state <= ST_SCALE;
            end
          end
        end
        ST_SCALE: begin
          if (phase) begin
            sc[cnt] <= 32'(r24);
            cnt     <= cnt + 2'd1;
            if (cnt == 2'(dll_pkg::STAGE_COUNT - 1)) begin
              state <= ST_A0;
            end
          end
        end
        ST_A0: if (phase) begin
          a_gain <= 26'(r24);
          state  <= ST_A1;
        end
        ST_A1: if (phase) begin
          a_gain <= 26'(r24);
          state  <= ST_A2;
        end
        ST_A2: if (phase) begin
          a_gain <= 26'(r24);
          state  <= ST_B0;
        end
        ST_B0: if (phase) begin
          b_acc <= 35'(r24 + dll_pkg::wide_t'(sc[1]));
          state <= ST_B1;
        end
        ST_B1: if (phase) begin
          b_acc <= 35'(r24 + dll_pkg::wide_t'(sc[2]));
          state <= ST_B2;
        end
        ST_B2: if (phase) begin
          b_acc <= 35'(dll_pkg::sat32(r24 + dll_pkg::wide_t'(sc[3])));
          state <= ST_CK;
        end
        ST_CK: if (phase) begin
          ck24  <= prod[35:10];
          state <= ST_XIN;
        end
        ST_XIN: if (phase) begin
          xin   <= dll_pkg::sat32(r24);
          state <= ST_AK;
        end
        ST_AK: if (phase) begin
          ak24  <= 29'(r17);
          state <= ST_NUM;
        end
        ST_NUM: if (phase) begin
          // linear first guess: num / (1 + A*k)
          div_neg   <= dl_val[65];
          div_q     <= 60'(dl_mag <<< 24);
          div_dsr   <= 28'(dl_dsr);
          div_rem   <= '0;
          div_cnt   <= 6'(dll_pkg::DIV_BITS);
          div_first <= 1'b1;
          state     <= ST_DIV;
        end
        ST_DIV: begin
          if (div_cnt != '0) begin
            div_rem <= 28'(trial_ge ? trial - {1'b0, div_dsr} : trial);
            div_q   <= {div_q[58:0], trial_ge};
            div_cnt <= div_cnt - 6'd1;
          end else begin
            y4 <= dll_pkg::sat32((div_first ? '0 : dll_pkg::wide_t'(y4)) + q_w);
            if (!div_first) begin
              nstep <= nstep + 1'b1;
            end
            state <= ST_TLOOK;
          end
        end
        ST_TLOOK: begin
          tab_lo <= tanh_rom[lo_idx];
          tab_hi <= tanh_rom[hi_idx];
          frac   <= p_pos[21:0];
          t_neg  <= z[32];
          state  <= ST_TINT;
        end
        ST_TINT: if (phase) begin
          tval  <= 25'(t_neg ? -tm : tm);
          state <= ST_KD;
        end
        ST_KD: if (phase) begin
          if (nstep == NS_W'(NEWTON_STEPS)) begin
            y_stage <= dll_pkg::sat32(inner_w);
            cnt     <= '0;
            state   <= ST_STG;
          end else begin
            inner <= 34'(inner_w);
            state <= ST_F;
          end
        end
        ST_F: if (phase) begin
          f_val <= 36'(r24 + dll_pkg::wide_t'(b_acc) - dll_pkg::wide_t'(y4));
          state <= ST_TT;
        end
        ST_TT: if (phase) begin
          slope <= 26'(dll_pkg::ONE24 - r24);
          state <= ST_DD;
        end
        ST_DD: if (phase) begin
          // Newton step: F / (1 + A*k*sat')
          div_neg   <= dl_val[65];
          div_q     <= 60'(dl_mag <<< 24);
          div_dsr   <= 28'(dl_dsr);
          div_rem   <= '0;
          div_cnt   <= 6'(dll_pkg::DIV_BITS);
          div_first <= 1'b0;
          state     <= ST_DIV;
        end
        ST_STG: if (phase) begin
          st[cnt] <= dll_pkg::sat32(dll_pkg::wide_t'(stg_y) + r24);
          y_stage <= stg_y;
          cnt     <= cnt + 2'd1;
          if (cnt == 2'(dll_pkg::STAGE_COUNT - 1)) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          // hold until the output register is free
          if (!m_axis_tvalid || m_axis_tready) begin
            if (y_stage > 32'sd8388607) begin
              m_axis_tdata <= 24'h7FFFFF;
            end else if (y_stage < -32'sd8388608) begin
              m_axis_tdata <= 24'h800000;
            end else begin
              m_axis_tdata <= y_stage[23:0];
            end
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `DLL_ASSERT_NEXT(a_clear_zeroes, s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == dll_pkg::ACT_CLEAR), (st[0] == '0) && (st[1] == '0) && (st[2] == '0) && (st[3] == '0), "clear item left a stage state set")
  `DLL_ASSERT_NOW(a_div_nonzero, state == ST_DIV, div_dsr != '0, "divider running with zero divisor")
  `DLL_ASSERT_NEXT(a_out_load, (state == ST_OUT) && (!m_axis_tvalid || m_axis_tready), m_axis_tvalid && (state == ST_IDLE), "result not loaded into free output register")
  `DLL_ASSERT_NOW(a_nstep_range, 1'b1, nstep <= NS_W'(NEWTON_STEPS), "Newton step count out of range")

endmodule

`default_nettype wire

// File: dv/tb_diode_ladder_lowpass.sv
// Self-checking testbench for the diode-ladder lowpass: stream stimulus, register writes and
// a bit-exact predictor of the filter held in a small scoreboard class. Depends on dll_pkg.
`default_nettype none

class ladder_scoreboard;
  longint      gain [4];
  longint      res;
  longint      stage [4];
  longint      tanh_lut [257];
  logic [23:0] expected_out [$];
  int          errors;

  function new();
    longint unsigned xi, x2, d, t;
    for (int i = 0; i <= 256; i++) begin
      xi = (longint'(i) << 26) / 256;
      x2 = (xi * xi + (64'd1 << 23)) >> 24;
      d  = 64'(49) << 24;
      for (int n = 23; n >= 0; n--) begin
        d = (64'(2 * n + 1) << 24) + (x2 << 24) / d;
      end
      t = (xi << 24) / d;
      if (t > 64'd16777215) begin
        t = 64'd16777215;
      end
      tanh_lut[i] = longint'(t);
    end
    for (int i = 0; i < 4; i++) begin
      gain[i]  = 8388608;
      stage[i] = 0;
    end
    res    = 0;
    errors = 0;
  endfunction

  function longint round_shift(longint v, int sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // tanh of a Q.20 value, Q.24 result, linear interpolation in the table
  function longint tanh_lookup(longint z);
    longint a, p, idx, t;
    a   = (z < 0) ? -z : z;
    p   = a * 256;
    idx = p >>> 22;
    if (idx >= 256) begin
      t = tanh_lut[256];
    end else begin
      t = tanh_lut[idx] + (((tanh_lut[idx + 1] - tanh_lut[idx]) * (p & 64'h3FFFFF)) >>> 22);
    end
    return (z < 0) ? -t : t;
  endfunction

  function longint diode_curve(longint y);
    return tanh_lookup(y + 262144) - tanh_lookup(262144);
  endfunction

  function longint diode_slope(longint y);
    longint t;
    t = tanh_lookup(y + 262144);
    return 64'sd16777216 - round_shift(t * t, 24);
  endfunction

  function void write_reg(int idx, longint v);
    if (idx < 4) begin
      gain[idx] = v & 64'hFFFFFF;
    end else if (idx == 4) begin
      res = v & 64'h1FFFF;
    end
  endfunction

  function void note_input(bit act, logic [23:0] smp);
    longint s [4];
    longint x, r, k17, ck24, xin, a_gain, b_off, ak24, num, den, y4, y, u, v, sv;
    longint inner, f, dd;
    if (act == dll_pkg::ACT_CLEAR) begin
      for (int i = 0; i < 4; i++) stage[i] = 0;
      expected_out.push_back('0);
      return;
    end
    x    = longint'($signed(smp));
    r    = (res > 65536) ? 65536 : res;
    k17  = 13 * r;
    ck24 = (13 * r * r) >>> 10;
    for (int i = 0; i < 4; i++) s[i] = round_shift(stage[i] * (64'sd16777216 - gain[i]), 24);
    a_gain = round_shift(round_shift(round_shift(gain[0] * gain[1], 24) * gain[2], 24)
                         * gain[3], 24);
    b_off = round_shift(gain[1] * s[0], 24) + s[1];
    b_off = round_shift(gain[2] * b_off, 24) + s[2];
    b_off = clip32(round_shift(gain[3] * b_off, 24) + s[3]);
    xin   = clip32(round_shift(x * (64'sd16777216 + ck24), 24));
    ak24  = round_shift(a_gain * k17, 17);
    num   = round_shift(a_gain * xin, 24) + b_off;
    den   = 64'sd16777216 + ak24;
    y4    = clip32((num * 64'sd16777216) / den);
    // Newton refinement of the feedback loop
    for (int it = 0; it < 4; it++) begin
      inner = xin - round_shift(k17 * diode_curve(y4), 21);
      f     = round_shift(a_gain * inner, 24) + b_off - y4;
      dd    = 64'sd16777216 + round_shift(ak24 * diode_slope(y4), 24);
      y4    = clip32(y4 + (f * 64'sd16777216) / dd);
    end
    u = clip32(xin - round_shift(k17 * diode_curve(y4), 21));
    y = u;
    for (int i = 0; i < 4; i++) begin
      sv       = stage[i];
      v        = round_shift((y - sv) * gain[i], 24);
      y        = clip32(v + sv);
      stage[i] = clip32(y + v);
    end
    if (y > 8388607) y = 8388607;
    if (y < -8388608) y = -8388608;
    expected_out.push_back(y[23:0]);
  endfunction

  function void check_result(logic [23:0] got);
    logic [23:0] want;
    if (expected_out.size() == 0) begin
      $error("sample_out: unexpected item, actual %0d", $signed(got));
      errors++;
      return;
    end
    want = expected_out.pop_front();
    if (got !== want) begin
      $error("sample_out: expected %0d, actual %0d", $signed(want), $signed(got));
      errors++;
    end
  endfunction
endclass

module tb_diode_ladder_lowpass;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic [0:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        wr_en;
  logic [2:0]  wr_index;
  logic [23:0] wr_data;

  ladder_scoreboard filt_model;
  int send_idle_pct;
  int recv_stall_pct;
  int quiet_cycles;

  diode_ladder_lowpass DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor both sides and run the watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) filt_model.note_input(s_axis_tuser[0], s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) filt_model.check_result(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_item(input bit act, input logic [23:0] smp);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= smp;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // drain the filter, then write one register
  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (filt_model.expected_out.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    filt_model.write_reg(int'(idx), longint'(val));
    @(posedge clk);
  endtask

  task automatic random_sample(output logic [23:0] smp);
    case ($urandom_range(3))
      0: smp = 24'($urandom);
      1: smp = 24'($signed(12'($urandom)));
      2: smp = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
      default: smp = 24'($signed(20'($urandom)));
    endcase
  endtask

  initial begin
    logic [23:0] smp;
    filt_model     = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    quiet_cycles   = 0;
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    m_axis_tready  = 1'b0;
    wr_en          = 1'b0;
    wr_index       = '0;
    wr_data        = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, clear, default registers
    send_item(dll_pkg::ACT_FILTER, 24'h7FFFFF);
    send_item(dll_pkg::ACT_FILTER, 24'h7FFFFF);
    send_item(dll_pkg::ACT_FILTER, 24'h800000);
    send_item(dll_pkg::ACT_CLEAR, 24'h123456);
    send_item(dll_pkg::ACT_FILTER, 24'h000000);
    send_item(dll_pkg::ACT_FILTER, 24'h100000);
    // full resonance and resonance above one
    write_reg(dll_pkg::REG_RESONANCE, 24'(dll_pkg::RES_MAX));
    send_item(dll_pkg::ACT_FILTER, 24'h7FFFFF);
    send_item(dll_pkg::ACT_FILTER, 24'h800000);
    write_reg(dll_pkg::REG_RESONANCE, 24'h1FFFF);
    send_item(dll_pkg::ACT_FILTER, 24'h400000);
    send_item(dll_pkg::ACT_FILTER, 24'hC00000);
    // gain of zero holds the stage, full gain passes through
    write_reg(dll_pkg::REG_GAIN_0, 24'hFFFFFF);
    write_reg(dll_pkg::REG_GAIN_1, 24'h000000);
    write_reg(dll_pkg::REG_GAIN_2, 24'hFFFFFF);
    write_reg(dll_pkg::REG_GAIN_3, 24'h000000);
    send_item(dll_pkg::ACT_FILTER, 24'h7FFFFF);
    send_item(dll_pkg::ACT_FILTER, 24'h800000);
    // out-of-range indexes are ignored
    for (int i = int'(dll_pkg::REG_RESONANCE) + 1; i < 8; i++) write_reg(3'(i), 24'hFFFFFF);
    send_item(dll_pkg::ACT_FILTER, 24'h200000);
    write_reg(dll_pkg::REG_GAIN_1, 24'hFFFFFF);
    write_reg(dll_pkg::REG_GAIN_3, 24'hFFFFFF);
    write_reg(dll_pkg::REG_RESONANCE, 24'h0);
    send_item(dll_pkg::ACT_FILTER, 24'h800000);
    send_item(dll_pkg::ACT_CLEAR, 24'h0);

    // random: register settings change per phase, idling cycles through its modes
    for (int ph = 0; ph < 8; ph++) begin
      for (int g = 0; g < 4; g++) begin
        case ($urandom_range(4))
          0: write_reg(3'(g), 24'h000000);
          1: write_reg(3'(g), 24'hFFFFFF);
          default: write_reg(3'(g), 24'($urandom));
        endcase
      end
      case ($urandom_range(3))
        0: write_reg(dll_pkg::REG_RESONANCE, 24'($urandom_range(131071)));
        1: write_reg(dll_pkg::REG_RESONANCE, 24'(dll_pkg::RES_MAX));
        default: write_reg(dll_pkg::REG_RESONANCE, 24'($urandom_range(65536)));
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      for (int n = 0; n < 216; n++) begin
        random_sample(smp);
        send_item(($urandom_range(99) < 4) ? dll_pkg::ACT_CLEAR : dll_pkg::ACT_FILTER, smp);
      end
    end

    s_axis_tvalid <= 1'b0;
    // let the monitor note the last accepted item before draining
    @(posedge clk);
    while (filt_model.expected_out.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (filt_model.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

`default_nettype wire
